// ===== rtl/spna_pkg.sv =====
// Shared types, constants and the power-of-three table for the sparse
// negacyclic polynomial audit. No dependencies.
package spna_pkg;

  localparam int TERM_COUNT      = 6;
  localparam int RING_LENGTH     = 128;
  localparam int FIELD_PRIME     = 257;
  localparam int ROOT_BASE       = 3;
  localparam int ROOT_COUNT      = (FIELD_PRIME - 1) / 2;
  localparam int ROOT_INDEX_W    = $clog2(ROOT_COUNT);
  localparam int EXP_W           = ROOT_INDEX_W + 1;
  localparam int DEF_ROOT_LANES  = 16;
  localparam int POS_W           = 7;
  localparam int COEF_W          = 3;
  localparam int HALF_RING       = RING_LENGTH / 2;
  localparam int LAG_W           = $clog2(HALF_RING);
  localparam int RES_W           = 9;
  localparam int ENERGY_W        = 12;
  localparam int ENERGY_MAX      = 4095;
  localparam int PAIR_COUNT      = TERM_COUNT * (TERM_COUNT - 1) / 2;

  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [RES_W-1:0]         res_t;
  typedef logic [LAG_W-1:0]         lag_t;
  typedef logic signed [5:0]        pval_t;
  typedef logic [ENERGY_W-1:0]      energy_t;

  typedef struct packed {
    logic vld;
    logic last;
  } issue_t;

  typedef logic [FIELD_PRIME-2:0][RES_W-1:0] pow_tbl_t;

  function automatic pow_tbl_t pow3_table();
    pow_tbl_t t;
    int acc;
    acc = 1;
    for (int k = 0; k < FIELD_PRIME - 1; k++) begin
      t[k] = RES_W'(acc);
      acc = (acc * ROOT_BASE) % FIELD_PRIME;
    end
    return t;
  endfunction

  localparam pow_tbl_t POW3 = pow3_table();

endpackage

// ===== rtl/spna_energy.sv =====
// Pair lanes for the negacyclic autocorrelation energy, four register stages.
// Depends on spna_pkg.
module spna_energy (
  input  logic              clk,
  input  spna_pkg::pos_t    pos  [spna_pkg::TERM_COUNT],
  input  spna_pkg::coef_t   coef [spna_pkg::TERM_COUNT],
  output spna_pkg::energy_t energy,
  output logic              invalid
);

  localparam int NP = spna_pkg::PAIR_COUNT;

  spna_pkg::lag_t  key_c [NP];
  spna_pkg::pval_t val_c [NP];
  logic            inv_c;

  spna_pkg::lag_t  key_q [NP];
  spna_pkg::pval_t val_q [NP];
  logic            inv_q;

  logic signed [9:0]  sum_c [NP];
  logic signed [9:0]  sum_q [NP];
  spna_pkg::pval_t    val2_q [NP];
  logic               inv2_q;

  logic signed [13:0] prod_q [NP];
  logic               inv3_q;

  logic signed [17:0] total_c;

  // lag and signed weight of every unordered pair
  always_comb begin
    int n;
    logic signed [7:0] d;
    logic [6:0] ad;
    spna_pkg::pval_t p;
    logic signed [9:0] eq;
    n = 0;
    eq = '0;
    for (int i = 0; i < spna_pkg::TERM_COUNT; i++) begin
      for (int j = i + 1; j < spna_pkg::TERM_COUNT; j++) begin
        d = $signed({1'b0, pos[i]}) - $signed({1'b0, pos[j]});
        ad = d[7] ? 7'(-d) : d[6:0];
        p = coef[i] * coef[j];
        key_c[n] = ad[spna_pkg::LAG_W-1:0];
        val_c[n] = '0;
        if (ad == '0) begin
          eq = eq + 10'(p);
        end else if (ad < 7'(spna_pkg::HALF_RING)) begin
          val_c[n] = p;
        end else if (ad > 7'(spna_pkg::HALF_RING)) begin
          key_c[n] = spna_pkg::LAG_W'(7'd0 - ad);
          val_c[n] = -p;
        end
        n++;
      end
    end
    inv_c = (eq != '0);
  end

  always_comb begin
    for (int a = 0; a < NP; a++) begin
      sum_c[a] = '0;
      for (int b = 0; b < NP; b++) begin
        if (key_q[a] == key_q[b]) begin
          sum_c[a] = sum_c[a] + 10'(val_q[b]);
        end
      end
    end
  end

  always_comb begin
    total_c = '0;
    for (int a = 0; a < NP; a++) begin
      total_c = total_c + 18'(prod_q[a]);
    end
  end

  always_ff @(posedge clk) begin
    key_q  <= key_c;
    val_q  <= val_c;
    inv_q  <= inv_c;
    sum_q  <= sum_c;
    val2_q <= val_q;
    inv2_q <= inv_q;
    for (int a = 0; a < NP; a++) begin
      prod_q[a] <= 14'(val2_q[a]) * 14'(sum_q[a]);
    end
    inv3_q  <= inv2_q;
    invalid <= inv3_q;
    if (inv3_q) begin
      energy <= '0;
    end else if (total_c > 18'sd4095) begin
      energy <= spna_pkg::ENERGY_W'(spna_pkg::ENERGY_MAX);
    end else begin
      energy <= total_c[spna_pkg::ENERGY_W-1:0];
    end
  end

endmodule

// ===== rtl/spna_root_lane.sv =====
// One root lane: evaluates the polynomial mod 257 at one odd power of 3
// per cycle, two register stages. Depends on spna_pkg.
module spna_root_lane #(
  parameter int LANE_ID = 0,
  parameter int LANES   = spna_pkg::DEF_ROOT_LANES
) (
  input  logic                                         clk,
  input  logic [spna_pkg::ROOT_INDEX_W-$clog2(LANES)-1:0] grp,
  input  spna_pkg::pos_t                               pos  [spna_pkg::TERM_COUNT],
  input  spna_pkg::coef_t                              coef [spna_pkg::TERM_COUNT],
  output logic                                         hit
);

  localparam int LANE_W = $clog2(LANES);

  logic [spna_pkg::ROOT_INDEX_W-1:0] idx;
  logic [spna_pkg::EXP_W-1:0]        e;
  spna_pkg::res_t                    pw_c [spna_pkg::TERM_COUNT];
  spna_pkg::res_t                    pw_q [spna_pkg::TERM_COUNT];
  spna_pkg::coef_t                   cf_q [spna_pkg::TERM_COUNT];
  logic signed [15:0]                sum_c;
  logic [14:0]                       mag;

  assign idx = {grp, LANE_W'(LANE_ID)};
  assign e   = {idx, 1'b1};

  always_comb begin
    logic [spna_pkg::EXP_W-1:0] k;
    for (int t = 0; t < spna_pkg::TERM_COUNT; t++) begin
      k = e * spna_pkg::EXP_W'(pos[t]);
      pw_c[t] = spna_pkg::POW3[k];
    end
  end

  // 256 = -1 mod 257: |sum| < 6400 is a multiple of 257 iff low byte == high part
  always_comb begin
    sum_c = '0;
    for (int t = 0; t < spna_pkg::TERM_COUNT; t++) begin
      sum_c = sum_c + 16'(cf_q[t]) * $signed({7'd0, pw_q[t]});
    end
    mag = sum_c[15] ? 15'(-sum_c) : sum_c[14:0];
  end

  always_ff @(posedge clk) begin
    pw_q <= pw_c;
    cf_q <= coef;
    hit  <= (mag[7:0] == 8'(mag[14:8]));
  end

endmodule

// ===== rtl/sparse_negacyclic_poly_audit.sv =====
// Top level of the sparse negacyclic polynomial audit: item register, root
// sweep sequencer, root lanes, energy unit and hit merge.
// Depends on spna_pkg, spna_energy and spna_root_lane.
//
// Usage: drive the six positions and coefficients with start high; the word
// is taken at a rising edge where start is high and busy is low. One result
// word per item appears on energy, energy_invalid and has_common_root,
// marked by done, which is high for a single cycle and is registered together
// with the word after the item's last root group.
// Items are paced by the sweep of the 128 odd powers of 3 over the root
// lanes; busy is high during that sweep and drops in its last cycle so the
// next word follows without a gap. The energy path is a four-stage pipeline
// that finishes inside the sweep at the default lane count. Results come
// out in input order.
// The receiver cannot stall: done is a strobe and each word must be taken
// when shown. Synchronous reset clears the sequencer, the pipeline tags and
// done; no item is made up across reset, and items in flight are dropped.
module sparse_negacyclic_poly_audit #(
  parameter int ROOT_LANES = spna_pkg::DEF_ROOT_LANES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  spna_pkg::pos_t        pos_a,
  input  spna_pkg::pos_t        pos_b,
  input  spna_pkg::pos_t        pos_c,
  input  spna_pkg::pos_t        pos_d,
  input  spna_pkg::pos_t        pos_e,
  input  spna_pkg::pos_t        pos_f,
  input  spna_pkg::coef_t       coef_a,
  input  spna_pkg::coef_t       coef_b,
  input  spna_pkg::coef_t       coef_c,
  input  spna_pkg::coef_t       coef_d,
  input  spna_pkg::coef_t       coef_e,
  input  spna_pkg::coef_t       coef_f,
  output logic                  done,
  output spna_pkg::energy_t     energy,
  output logic                  energy_invalid,
  output logic                  has_common_root
);

  localparam int LANE_W  = $clog2(ROOT_LANES);
  localparam int GROUP_W = spna_pkg::ROOT_INDEX_W - LANE_W;
  localparam int GROUPS  = spna_pkg::ROOT_COUNT / ROOT_LANES;

  spna_pkg::pos_t    pos_q  [spna_pkg::TERM_COUNT];
  spna_pkg::coef_t   coef_q [spna_pkg::TERM_COUNT];
  logic              active;
  logic [GROUP_W-1:0] cnt;
  logic              last_grp;
  logic              accept;
  spna_pkg::issue_t  tag_a;
  spna_pkg::issue_t  tag_b;
  logic [ROOT_LANES-1:0] hits;
  logic              acc;
  spna_pkg::energy_t en_val;
  logic              en_inv;

  assign last_grp = (cnt == GROUP_W'(GROUPS - 1));
  assign busy     = active && !last_grp;
  assign accept   = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (accept) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      if (last_grp) begin
        active <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q  <= '{pos_a, pos_b, pos_c, pos_d, pos_e, pos_f};
      coef_q <= '{coef_a, coef_b, coef_c, coef_d, coef_e, coef_f};
    end
  end

  spna_energy u_energy (
    .clk     (clk),
    .pos     (pos_q),
    .coef    (coef_q),
    .energy  (en_val),
    .invalid (en_inv)
  );

  for (genvar l = 0; l < ROOT_LANES; l++) begin : g_lane
    spna_root_lane #(
      .LANE_ID (l),
      .LANES   (ROOT_LANES)
    ) u_lane (
      .clk  (clk),
      .grp  (cnt),
      .pos  (pos_q),
      .coef (coef_q),
      .hit  (hits[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
      tag_b <= '0;
      acc   <= 1'b0;
      done  <= 1'b0;
    end else begin
      tag_a <= '{vld: active, last: active && last_grp};
      tag_b <= tag_a;
      if (tag_b.vld) begin
        acc <= tag_b.last ? 1'b0 : (acc | (|hits));
      end
      done <= tag_b.vld && tag_b.last;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_b.vld && tag_b.last) begin
      energy          <= en_val;
      energy_invalid  <= en_inv;
      has_common_root <= acc | (|hits);
    end
  end

endmodule

// ===== rtl/spna_checker.sv =====
// Port-level checks for the sparse negacyclic polynomial audit, bound to the
// top level. Depends on sparse_negacyclic_poly_audit.
module spna_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [11:0] energy,
  input logic        energy_invalid
);

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for two cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after accept");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && energy_invalid) |-> (energy == 12'd0))
    else $error("invalid energy word not zero");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 11))
    else $error("result without matching accept");

endmodule

bind sparse_negacyclic_poly_audit spna_checker u_spna_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .energy         (energy),
  .energy_invalid (energy_invalid)
);
